/* rtl/second_order_oscillator_filter_assert.svh */
// Assertion macros for the second-order oscillator filter.
`ifndef SECOND_ORDER_OSCILLATOR_FILTER_ASSERT_SVH
`define SECOND_ORDER_OSCILLATOR_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SOF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sof assertion failed");
`define SOF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sof assertion failed");
`else
`define SOF_ASSERT_NOW(lbl, ante, cons)
`define SOF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/sof_pkg.sv */
// Package: widths, register codes, controller types for the oscillator filter.
package sof_pkg;
	localparam int DATA_W = 32;
	localparam int FRAC_BITS = 16;
	localparam int COEF_BITS = 28;
	localparam int DT_W = 24;
	localparam int ZETA_W = 17;
	localparam logic [ZETA_W-1:0] ZETA_ONE = 17'h10000;
	localparam int PADDR_W = 3;
	localparam int DIV_STEPS = COEF_BITS + 1;
	localparam int MAC_TERMS = 5;

	localparam logic REG_FREQ = 1'b0;
	localparam logic REG_ZETA = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_MULA, S_SHIFT, S_MULP, S_MULR, S_DEN, S_DIV, S_COEF, S_MAC, S_FIN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_a;
		logic       shift;
		logic       mul_p;
		logic       mul_r;
		logic       den;
		logic       div;
		logic       div_first;
		logic       coef;
		logic       mac_mul;
		logic       mac_acc;
		logic [2:0] mac_sel;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic bypass;
	} stat_t;
endpackage

/* rtl/sof_if.sv */
// Item channel interfaces: sample items in, result items out.
interface sof_in_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic [sof_pkg::DT_W-1:0]         time_step;
	logic signed [sof_pkg::DATA_W-1:0] sample_in;
	logic signed [sof_pkg::DATA_W-1:0] preload_value;
	modport source (output valid, op, time_step, sample_in, preload_value, input ready);
	modport sink (input valid, op, time_step, sample_in, preload_value, output ready);
endinterface

interface sof_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [sof_pkg::DATA_W-1:0] value_out;
	logic                             held;
	modport source (output valid, value_out, held, input ready);
	modport sink (input valid, value_out, held, output ready);
endinterface

/* rtl/sof_ctrl.sv */
// Controller: sequences coefficient math, division, MAC and commit.
module sof_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_ready,
	input  sof_pkg::stat_t stat,
	output sof_pkg::cmd_t  cmd,
	output logic           in_ready,
	output logic           out_valid
);
	import sof_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_MULA;
			S_MULA:  state_d = stat.bypass ? S_FIN : S_SHIFT;
			S_SHIFT: state_d = S_MULP;
			S_MULP:  state_d = S_MULR;
			S_MULR:  state_d = S_DEN;
			S_DEN:   state_d = S_DIV;
			S_DIV:   if (cnt_q == 5'(DIV_STEPS - 1)) state_d = S_COEF;
			S_COEF:  state_d = S_MAC;
			S_MAC:   if (cnt_q == 5'(MAC_TERMS)) state_d = S_FIN;
			S_FIN:   if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_MULA:  cmd.mul_a = 1'b1;
			S_SHIFT: cmd.shift = 1'b1;
			S_MULP:  cmd.mul_p = 1'b1;
			S_MULR:  cmd.mul_r = 1'b1;
			S_DEN:   cmd.den = 1'b1;
			S_DIV: begin
				cmd.div = 1'b1;
				cmd.div_first = (cnt_q == 5'd0);
			end
			S_COEF:  cmd.coef = 1'b1;
			S_MAC: begin
				cmd.mac_mul = (cnt_q < 5'(MAC_TERMS));
				cmd.mac_acc = (cnt_q != 5'd0);
				cmd.mac_sel = cnt_q[2:0];
			end
			S_FIN:   cmd.commit = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else cnt_q <= cnt_q + 5'd1;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

/* rtl/sof_dp.sv */
// Datapath: Tustin coefficients, two restoring dividers, shared MAC, taps.
module sof_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sof_pkg::cmd_t                    cmd,
	input  logic                             op,
	input  logic [sof_pkg::DT_W-1:0]         time_step,
	input  logic signed [sof_pkg::DATA_W-1:0] sample_in,
	input  logic signed [sof_pkg::DATA_W-1:0] preload_value,
	input  logic [sof_pkg::DATA_W-1:0]       freq,
	input  logic [sof_pkg::ZETA_W-1:0]       zeta,
	output sof_pkg::stat_t                   stat,
	output logic signed [sof_pkg::DATA_W-1:0] value_out,
	output logic                             held
);
	import sof_pkg::*;

	logic                     op_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [DATA_W-1:0] u_q, pv_q;
	logic signed [DATA_W-1:0] cur_q, u1_q, u2_q, y1_q, y2_q;
	logic [55:0]              wdt_c;
	logic [39:0]              a_q;
	logic [3:0]               k_c, k_q;
	logic [27:0]              b_q;
	logic [55:0]              pn_q;
	logic [44:0]              zb_q;
	logic [52:0]              zs_c;
	logic [54:0]              rn_c;
	logic [50:0]              qn_c;
	logic [56:0]              den_q;
	logic [57:0]              remp_q, remq_q, tp_c, tq_c;
	logic                     gep_c, geq_c;
	logic [28:0]              pq_q, qq_q;
	logic signed [DATA_W-1:0] p2_c, q2_c;
	logic signed [DATA_W-1:0] c_q [MAC_TERMS];
	logic signed [DATA_W-1:0] tap_c;
	logic signed [63:0]       prod_q, acc_q, rnd_c;
	logic signed [35:0]       yw_c;
	logic signed [DATA_W-1:0] y_c;

	assign stat.bypass = op_q || (dt_q == '0);
	assign wdt_c = 56'(freq) * 56'(dt_q);

	always_comb begin
		k_c = 4'd12;
		for (int i = 12; i >= 0; i--)
			if ((a_q >> i) < 40'h10000000) k_c = 4'(i);
	end

	assign zs_c = {zb_q, 8'b0} >> k_q;
	assign rn_c = {zs_c, 2'b0};
	assign qn_c = 51'(1) << (6'd50 - {1'b0, k_q, 1'b0});

	assign tp_c = cmd.div_first ? remp_q : {remp_q[56:0], 1'b0};
	assign tq_c = cmd.div_first ? remq_q : {remq_q[56:0], 1'b0};
	assign gep_c = tp_c >= {1'b0, den_q};
	assign geq_c = tq_c >= {1'b0, den_q};

	assign p2_c = $signed({2'b0, pq_q, 1'b0});
	assign q2_c = $signed({2'b0, qq_q, 1'b0});

	always_comb begin
		unique case (cmd.mac_sel)
			3'd0:    tap_c = u_q;
			3'd1:    tap_c = u1_q;
			3'd2:    tap_c = u2_q;
			3'd3:    tap_c = y1_q;
			default: tap_c = y2_q;
		endcase
	end

	assign rnd_c = acc_q + (64'sd1 <<< (COEF_BITS - 1));
	assign yw_c = rnd_c[63:28];
	always_comb begin
		if (yw_c > 36'sh07FFFFFFF) y_c = 32'sh7FFFFFFF;
		else if (yw_c < -36'sh080000000) y_c = 32'sh80000000;
		else y_c = yw_c[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			dt_q <= time_step;
			u_q <= sample_in;
			pv_q <= preload_value;
		end
		if (cmd.mul_a) a_q <= wdt_c[55:16];
		if (cmd.shift) begin
			k_q <= k_c;
			b_q <= 28'(a_q >> k_c);
		end
		if (cmd.mul_p) pn_q <= 56'(b_q) * 56'(b_q);
		if (cmd.mul_r) zb_q <= 45'(zeta) * 45'(b_q);
		if (cmd.den) begin
			den_q <= 57'(pn_q) + 57'(rn_c) + 57'(qn_c);
			remp_q <= 58'(pn_q);
			remq_q <= 58'(qn_c);
			pq_q <= '0;
			qq_q <= '0;
		end
		if (cmd.div) begin
			remp_q <= gep_c ? tp_c - {1'b0, den_q} : tp_c;
			remq_q <= geq_c ? tq_c - {1'b0, den_q} : tq_c;
			pq_q <= {pq_q[27:0], gep_c};
			qq_q <= {qq_q[27:0], geq_c};
		end
		if (cmd.coef) begin
			c_q[0] <= $signed({3'b0, pq_q});
			c_q[1] <= p2_c;
			c_q[2] <= $signed({3'b0, pq_q});
			c_q[3] <= q2_c - p2_c;
			c_q[4] <= 32'sh10000000 - p2_c - q2_c;
			acc_q <= '0;
		end
		if (cmd.mac_mul) prod_q <= 64'(c_q[cmd.mac_sel]) * 64'(tap_c);
		if (cmd.mac_acc) acc_q <= acc_q + prod_q;
		if (cmd.commit) begin
			if (op_q) begin
				value_out <= pv_q;
				held <= 1'b1;
			end else if (dt_q == '0) begin
				value_out <= cur_q;
				held <= 1'b1;
			end else begin
				value_out <= y_c;
				held <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			u1_q <= '0;
			u2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (cmd.commit) begin
			if (op_q) begin
				cur_q <= pv_q;
				y1_q <= pv_q;
				y2_q <= pv_q;
			end else if (dt_q != '0) begin
				cur_q <= y_c;
				u2_q <= u1_q;
				u1_q <= u_q;
				y2_q <= y1_q;
				y1_q <= y_c;
			end
		end
	end
endmodule

/* rtl/second_order_oscillator_filter.sv */
// Top level: APB registers, controller and datapath of the oscillator filter.
//
//  channel   dir  handshake       payload
//  samples   in   valid/ready     op, time_step, sample_in, preload_value
//  results   out  valid/ready     value_out, held
//  apb       in   psel/penable    paddr, pwdata, prdata (pready tied high)
//
// A filter step runs from accept through the bit-serial restoring dividers
// and the shared 32x32 MAC over the five taps to the result. Preload and
// zero time step items skip the coefficient math and the MAC. One item is in work at a
// time; the result register frees the controller once it is loaded, and a
// stalled result holds the next item in its final state. Reset clears the u1, u2, y1, y2 taps.
`include "second_order_oscillator_filter_assert.svh"
module second_order_oscillator_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	sof_in_if.sink                      samples,
	sof_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sof_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import sof_pkg::*;

	logic [DATA_W-1:0] freq_q;
	logic [ZETA_W-1:0] zeta_q;
	logic              wr;
	cmd_t              cmd;
	stat_t             stat;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= 32'h0001_0000;
			zeta_q <= ZETA_ONE;
		end else if (wr) begin
			if (paddr[2] == REG_FREQ) freq_q <= pwdata;
			else if (pwdata[16:0] > ZETA_ONE) zeta_q <= ZETA_ONE;
			else zeta_q <= pwdata[16:0];
		end
	end

	assign prdata = (paddr[2] == REG_ZETA) ? {15'b0, zeta_q} : freq_q;

	sof_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (samples.ready),
		.out_valid (results.valid)
	);

	sof_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (samples.op),
		.time_step     (samples.time_step),
		.sample_in     (samples.sample_in),
		.preload_value (samples.preload_value),
		.freq          (freq_q),
		.zeta          (zeta_q),
		.stat          (stat),
		.value_out     (results.value_out),
		.held          (results.held)
	);

	`SOF_ASSERT_NOW(a_zeta_clamped, 1'b1, zeta_q <= ZETA_ONE)
	`SOF_ASSERT_NEXT(a_busy_after_accept, samples.valid && samples.ready, !samples.ready)
	`SOF_ASSERT_NOW(a_commit_slot_free, cmd.commit, !results.valid || results.ready)
endmodule

/* sim/tb_second_order_oscillator_filter.sv */
// Self-checking testbench for the second-order oscillator filter: predicts each result item.
`timescale 1ns / 100ps
module tb_second_order_oscillator_filter;
	import sof_pkg::*;

	localparam logic OP_STEP = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;
	localparam logic [PADDR_W-1:0] ADDR_FREQ = {REG_FREQ, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_ZETA = {REG_ZETA, 2'b00};

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     held;
	} filt_res_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sof_in_if samples();
	sof_out_if results();

	second_order_oscillator_filter dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [31:0] omega;
	logic [16:0] zeta;
	logic signed [63:0] y_now, u1, u2, y1, y2;

	filt_res_t expected_q[$];
	int errors;
	int src_idle_pct, dst_stall_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [63:0] coef_ratio(logic [63:0] num, logic [63:0] den);
		logic [63:0] q, rem;
		q = 0;
		rem = num;
		if (rem >= den) begin
			rem = rem - den;
			q = 1;
		end
		for (int i = 0; i < COEF_BITS; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic filt_res_t filter_predict(logic op, logic [DT_W-1:0] dt,
			logic signed [31:0] u_in, logic signed [31:0] pre);
		filt_res_t r;
		logic [63:0] a, b, pn, rn, qn, den, p, q, rr;
		logic signed [63:0] u, ca, cb, cd, ce, acc, rnd, y;
		int k;
		u = u_in;
		if (op == OP_PRELOAD) begin
			y_now = pre;
			y1 = pre;
			y2 = pre;
			r.value = pre;
			r.held = 1'b1;
			return r;
		end
		if (dt == 0) begin
			r.value = y_now[31:0];
			r.held = 1'b1;
			return r;
		end
		a = ({32'd0, omega} * {40'd0, dt}) >> FRAC_BITS;
		k = 0;
		while ((a >> k) >= (64'd1 << 28)) k++;
		b = a >> k;
		pn = b * b;
		rn = 4 * ((({47'd0, zeta} * b) << 8) >> k);
		qn = 64'd1 << (50 - 2 * k);
		den = pn + rn + qn;
		p = coef_ratio(pn, den);
		q = coef_ratio(qn, den);
		rr = (64'd1 << COEF_BITS) - p - q;
		ca = p;
		cb = 2 * p;
		cd = 2 * $signed(p) - 2 * $signed(q);
		ce = (64'sd1 <<< COEF_BITS) - 2 * $signed(rr);
		acc = ca * u + cb * u1 + ca * u2 - cd * y1 - ce * y2;
		rnd = acc + (64'sd1 <<< (COEF_BITS - 1));
		y = sat32(rnd >>> COEF_BITS);
		y_now = y;
		u2 = u1;
		u1 = u;
		y2 = y1;
		y1 = y;
		r.value = y[31:0];
		r.held = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// result checker and receiver backpressure
	initial begin
		filt_res_t w;
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected item", results.value_out, 0);
				end else begin
					w = expected_q.pop_front();
					if (results.value_out !== w.value)
						report_mismatch("value_out", results.value_out, w.value);
					if (results.held !== w.held)
						report_mismatch("held", results.held, w.held);
				end
			end
			@(negedge clk);
			results.ready <= ($urandom_range(99) >= dst_stall_pct);
		end
	end

	// valid stays up after an accept until the next item or drain replaces it
	task automatic send_item(logic op, logic [DT_W-1:0] dt, logic signed [31:0] u,
			logic signed [31:0] pre);
		while ($urandom_range(99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			@(negedge clk);
		end
		samples.valid <= 1'b1;
		samples.op <= op;
		samples.time_step <= dt;
		samples.sample_in <= u;
		samples.preload_value <= pre;
		do @(posedge clk); while (!samples.ready);
		expected_q.push_back(filter_predict(op, dt, u, pre));
		@(negedge clk);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_FREQ) omega = data;
		else zeta = (data[16:0] > ZETA_ONE) ? ZETA_ONE : data[16:0];
		@(negedge clk);
	endtask

	task automatic set_filter(logic [31:0] w, logic [31:0] z);
		drain();
		apb_write(ADDR_FREQ, w);
		apb_write(ADDR_ZETA, z);
	endtask

	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(65535)) - 32768;
			default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
		endcase
	endfunction

	task automatic test_directed();
		send_item(OP_STEP, 24'd0, 32'sd0, 32'sd0);
		send_item(OP_STEP, 24'hFFFFFF, 32'sh7FFFFFFF, 32'sd0);
		send_item(OP_STEP, 24'd1, 32'sh80000000, 32'sd0);
		send_item(OP_PRELOAD, 24'hFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
		send_item(OP_STEP, 24'd0, 32'sh12345, 32'sh7FFFFFFF);
		send_item(OP_PRELOAD, 24'd0, 32'sd0, 32'sh7FFFFFFF);
		send_item(OP_STEP, 24'h100000, 32'sh80000000, 32'sd0);
		set_filter(32'hFFFFFFFF, 32'h1FFFF);
		send_item(OP_STEP, 24'hFFFFFF, 32'sh7FFFFFFF, 32'sd0);
		send_item(OP_STEP, 24'hFFFFFF, 32'sh80000000, 32'sd0);
		set_filter(32'd0, 32'd0);
		send_item(OP_STEP, 24'h800000, 32'sh7FFFFFFF, 32'sd0);
		send_item(OP_STEP, 24'hFFFFFF, 32'sh00010000, 32'sd0);
		set_filter(32'h00640000, 32'd0);
		send_item(OP_PRELOAD, 24'd0, 32'sd0, 32'sh7FFF0000);
		send_item(OP_STEP, 24'h040000, 32'sh80000000, 32'sd0);
		send_item(OP_STEP, 24'h040000, 32'sh80000000, 32'sd0);
		send_item(OP_STEP, 24'h040000, 32'sh7FFFFFFF, 32'sd0);
		drain();
		apb_write(3'd6, 32'hFFFFFFFF);
		send_item(OP_STEP, 24'h000100, 32'sh00010000, 32'sd0);
	endtask

	task automatic test_random(int n);
		logic op;
		logic [DT_W-1:0] dt;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(99) < 8) ? OP_PRELOAD : OP_STEP;
			case ($urandom_range(5))
				0: dt = '0;
				1: dt = DT_W'($urandom);
				default: dt = DT_W'($urandom_range(24'h020000));
			endcase
			send_item(op, dt, rand_sample(), rand_sample());
			if (i == n / 2) drain();
		end
	endtask

	initial begin
		errors = 0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		omega = 32'd65536;
		zeta = ZETA_ONE;
		y_now = 0; u1 = 0; u2 = 0; y1 = 0; y2 = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		samples.valid = 1'b0;
		samples.op = OP_STEP;
		samples.time_step = '0;
		samples.sample_in = '0;
		samples.preload_value = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0; dst_stall_pct = 0; end
				1: begin src_idle_pct = 49; dst_stall_pct = 0; end
				2: begin src_idle_pct = 0; dst_stall_pct = 49; end
				default: begin src_idle_pct = 29; dst_stall_pct = 29; end
			endcase
			case (ph)
				0: set_filter(32'h00010000, 32'h10000);
				1: set_filter(32'h000A0000, 32'h02000);
				2: set_filter($urandom, $urandom_range(17'h1FFFF));
				3: set_filter(32'h01000000, 32'h08000);
				4: set_filter(32'h00008000, 32'd0);
				5: set_filter($urandom_range(32'h00400000), $urandom_range(17'h10000));
				6: set_filter(32'hFFFFFFFF, 32'h0FFFF);
				default: set_filter($urandom, $urandom);
			endcase
			test_random(210);
		end
		drain();
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
